// ===== sv/adc_ladder_key_debounce_defines.svh =====
// Assertion macros used by the keypad debounce checker.
`ifndef ADC_LADDER_KEY_DEBOUNCE_DEFINES_SVH
`define ADC_LADDER_KEY_DEBOUNCE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ALKD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keypad debounce check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ALKD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keypad debounce check failed");

`endif

// ===== sv/alkd_pkg.sv =====
// Shared types and constants of the ladder keypad debounce block.
package alkd_pkg;

    localparam int KEY_COUNT_DEF   = 16;
    localparam int KEY_SPACING_DEF = 64;
    localparam int SAMPLE_BITS_DEF = 10;

    localparam int SAMPLE_W = 10;
    localparam int KEY_W    = 5;
    localparam int TOL_W    = 5;
    localparam int CNT_W    = 8;
    localparam int CFG_W    = 8;
    localparam int IDX_W    = 2;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    localparam logic [IDX_W-1:0] REG_TOLERANCE = 2'd0;
    localparam logic [IDX_W-1:0] REG_REPEAT_THR = 2'd1;
    localparam logic [IDX_W-1:0] REG_REPEAT_RELOAD = 2'd2;

    localparam logic [TOL_W-1:0] TOL_RESET    = 5'd16;
    localparam logic [CNT_W-1:0] THR_RESET    = 8'd100;
    localparam logic [CNT_W-1:0] RELOAD_RESET = 8'd90;

    // classified sample handed from front to back
    typedef struct packed {
        logic             release_key;
        logic [KEY_W-1:0] key;
    } cls_t;

    typedef struct packed {
        logic             key_event;
        logic [KEY_W-1:0] key_number;
        logic [KEY_W-1:0] held_key;
    } result_t;

endpackage

// ===== sv/alkd_front.sv =====
// Front end: accepts samples and matches them against the key windows.
module alkd_front import alkd_pkg::*; #(
    parameter int KEY_COUNT   = KEY_COUNT_DEF,
    parameter int KEY_SPACING = KEY_SPACING_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [TOL_W-1:0]    tolerance,
    input  logic                q_full,
    output logic                q_push,
    output cls_t                q_data
);

    localparam int CMP_W = $clog2(KEY_COUNT * KEY_SPACING + (1 << SAMPLE_W) + (1 << TOL_W)) + 1;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = (SAMPLE_BITS >= SAMPLE_W) ?
        {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << SAMPLE_BITS) - 1);

    logic [CMP_W-1:0]   s_ext;
    logic [CMP_W-1:0]   t_ext;
    logic [CMP_W-1:0]   s_hi;
    logic [KEY_COUNT:1] hit;
    logic [KEY_W-1:0]   match;

    assign s_ext = CMP_W'(sample & SAMPLE_MASK);
    assign t_ext = CMP_W'(tolerance);
    assign s_hi  = s_ext + t_ext;

    // window test per key: centre - tol <= s <= centre + tol
    always_comb
    begin
        logic [CMP_W-1:0] centre;
        for (int k = 1; k <= KEY_COUNT; k++)
        begin
            centre = CMP_W'(k * KEY_SPACING);
            hit[k] = (s_hi >= centre) && (s_ext <= centre + t_ext);
        end
    end

    // lowest matching key wins
    always_comb
    begin
        match = '0;
        for (int k = KEY_COUNT; k >= 1; k--)
        begin
            if (hit[k])
            begin
                match = KEY_W'(k);
            end
        end
    end

    assign s_tready            = !q_full;
    assign q_push              = s_tvalid && !q_full;
    assign q_data.key          = match;
    assign q_data.release_key  = s_hi < CMP_W'(KEY_SPACING);

endmodule

// ===== sv/alkd_fifo.sv =====
// Two-entry queue between the classifier and the debounce state machine.
module alkd_fifo import alkd_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cls_t push_data,
    input  logic pop,
    output logic full,
    output logic empty,
    output cls_t head
);

    cls_t        mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    assign full  = count_reg[1];
    assign empty = (count_reg == 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

endmodule

// ===== sv/alkd_back.sv =====
// Back end: debounce history, key latch, auto-repeat counter and result register.
module alkd_back import alkd_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  cls_t             q_head,
    output logic             q_pop,
    input  logic [CNT_W-1:0] repeat_threshold,
    input  logic [CNT_W-1:0] repeat_reload,
    output logic             out_valid,
    input  logic             out_ready,
    output result_t          out_data
);

    logic [KEY_W-1:0] latched_reg, latched_next;
    logic [KEY_W-1:0] hist0_reg;
    logic [KEY_W-1:0] hist1_reg;
    logic [CNT_W-1:0] hold_reg, hold_next;
    logic             valid_reg;
    result_t          result_reg, result_next;

    assign q_pop = !q_empty && (!valid_reg || out_ready);

    always_comb
    begin
        logic [KEY_W-1:0] lat0;
        logic [CNT_W-1:0] hold0;
        logic [CNT_W-1:0] base;
        logic [CNT_W:0]   inc;
        logic             stable;
        logic             ev;

        lat0   = q_head.release_key ? '0 : latched_reg;
        hold0  = q_head.release_key ? '0 : hold_reg;
        stable = (q_head.key != '0) && (hist0_reg == q_head.key) && (hist1_reg == q_head.key);
        ev     = 1'b0;
        latched_next = lat0;
        hold_next    = hold0;
        base   = hold0;
        inc    = '0;
        if (stable)
        begin
            if (lat0 == '0)
            begin
                latched_next = q_head.key;
                base = '0;
                ev   = 1'b1;
            end
            if (latched_next == q_head.key)
            begin
                // wide increment so a count of 255 still reaches the threshold
                inc = {1'b0, base} + 1'b1;
                if (inc >= {1'b0, repeat_threshold})
                begin
                    hold_next = repeat_reload;
                    ev = 1'b1;
                end
                else
                begin
                    hold_next = inc[CNT_W-1:0];
                end
            end
            else
            begin
                hold_next = '0;
            end
        end
        result_next.key_event  = ev;
        result_next.key_number = ev ? q_head.key : '0;
        result_next.held_key   = latched_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_reg <= '0;
            hist0_reg   <= '0;
            hist1_reg   <= '0;
            hold_reg    <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                latched_reg <= latched_next;
                hold_reg    <= hold_next;
                hist1_reg   <= hist0_reg;
                hist0_reg   <= q_head.key;
                valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = result_reg;

endmodule

// ===== sv/adc_ladder_key_debounce.sv =====
// A taken sample is written to the queue, then popped into the result register, where it waits for the receiver.
// Throughput: one sample per cycle while the receiver does not stall the result register.
// A two-entry queue lets input and output stall independently.
// Reset (async, low) clears key latch, history, hold count and the queue;
// tolerance, threshold and reload return to 16, 100 and 90.
module adc_ladder_key_debounce import alkd_pkg::*; #(
    parameter int KEY_COUNT   = KEY_COUNT_DEF,
    parameter int KEY_SPACING = KEY_SPACING_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [9:0] sample
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [0] key_event, [5:1] key_number, [10:6] held_key
    input  logic                   cfg_we,
    input  logic [IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    logic [TOL_W-1:0] tol_reg;
    logic [CNT_W-1:0] thr_reg;
    logic [CNT_W-1:0] reload_reg;

    logic    q_full;
    logic    q_empty;
    logic    q_push;
    logic    q_pop;
    cls_t    q_in;
    cls_t    q_head;
    result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg    <= TOL_RESET;
            thr_reg    <= THR_RESET;
            reload_reg <= RELOAD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TOLERANCE:     tol_reg    <= cfg_data[TOL_W-1:0];
                REG_REPEAT_THR:    thr_reg    <= cfg_data[CNT_W-1:0];
                REG_REPEAT_RELOAD: reload_reg <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    alkd_front #(
        .KEY_COUNT   (KEY_COUNT),
        .KEY_SPACING (KEY_SPACING),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .sample    (s_tdata[SAMPLE_W-1:0]),
        .tolerance (tol_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    alkd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    alkd_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_head           (q_head),
        .q_pop            (q_pop),
        .repeat_threshold (thr_reg),
        .repeat_reload    (reload_reg),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_data         (res)
    );

    assign m_tdata = {{(OUT_TDATA_W - 1 - 2 * KEY_W){1'b0}},
                      res.held_key, res.key_number, res.key_event};

endmodule

// ===== sv/alkd_checker.sv =====
// Port-level checks of the keypad debounce block, bound to the top level.
`include "adc_ladder_key_debounce_defines.svh"

module alkd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a stalled result holds
    `ALKD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // a reported key is nonzero exactly when an event is flagged
    `ALKD_ASSERT_NOW(a_event_key, m_tvalid, m_tdata[0] == (m_tdata[5:1] != 5'd0))

    // an event always reports the key that is latched
    `ALKD_ASSERT_NOW(a_event_held, m_tvalid && m_tdata[0], m_tdata[10:6] == m_tdata[5:1])

    // keys stay in range and padding is zero
    `ALKD_ASSERT_NOW(a_range, m_tvalid,
        (m_tdata[10:6] <= 5'd16) && (m_tdata[5:1] <= 5'd16) && (m_tdata[15:11] == 5'd0))

    // the queue only fills up behind a waiting result
    `ALKD_ASSERT_NOW(a_full_stalls, !s_tready, m_tvalid)

endmodule

bind adc_ladder_key_debounce alkd_checker u_alkd_checker (.*);

// ===== test/tb_top.sv =====
// Self-checking testbench of the resistor-ladder keypad debounce block.
`timescale 1ns / 1ps

module tb_top;
    import alkd_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLDOFF_CYCLES = 150;
    localparam int RANDOM_PER_PHASE = 258;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [IDX_W-1:0]      idx;
        logic [CFG_W-1:0]      val;
        logic [SAMPLE_W-1:0]   smp;
        bit                    typed;
        result_t               res;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we = 1'b0;
    logic [IDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;

    // key debounce shadow state
    logic [TOL_W-1:0]    shadow_tol = TOL_RESET;
    logic [CNT_W-1:0]    shadow_thr = THR_RESET;
    logic [CNT_W-1:0]    shadow_reload = RELOAD_RESET;
    logic [KEY_W-1:0]    shadow_latched = '0;
    logic [KEY_W-1:0]    shadow_hist [3] = '{'0, '0, '0};
    logic [CNT_W-1:0]    shadow_hold = '0;

    result_t   expected_reports[$];
    stim_row_t directed[$];
    result_t   got;
    result_t   want;

    int send_idle = 0;
    int recv_stall = 0;
    int hold_reqs = 0;
    int hold_served = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    int error_cnt = 0;
    int samples_sent = 0;
    int reports_seen = 0;
    int events_seen = 0;
    int writes_done = 0;

    adc_ladder_key_debounce dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Advance the shadow debouncer by one sample and return its report.
    function automatic result_t debounce_step(input logic [SAMPLE_W-1:0] smp);
        result_t r;
        int s;
        int tol;
        int m;
        int nxt;
        s = smp;
        tol = shadow_tol;
        r = '0;
        m = 0;
        if (s < KEY_SPACING_DEF - tol)
        begin
            shadow_latched = '0;
            shadow_hold = '0;
        end
        for (int k = 1; k <= KEY_COUNT_DEF; k++)
        begin
            if (m == 0 && s >= k * KEY_SPACING_DEF - tol && s <= k * KEY_SPACING_DEF + tol)
                m = k;
        end
        shadow_hist[2] = shadow_hist[1];
        shadow_hist[1] = shadow_hist[0];
        shadow_hist[0] = KEY_W'(m);
        if (m != 0 && shadow_hist[1] == m && shadow_hist[2] == m)
        begin
            if (shadow_latched == 0)
            begin
                shadow_latched = KEY_W'(m);
                shadow_hold = '0;
                r.key_event = 1'b1;
                r.key_number = KEY_W'(m);
            end
            if (shadow_latched == m)
            begin
                // wide increment so a count of 255 still reaches the threshold
                nxt = int'(shadow_hold) + 1;
                if (nxt >= int'(shadow_thr))
                begin
                    shadow_hold = shadow_reload;
                    r.key_event = 1'b1;
                    r.key_number = KEY_W'(m);
                end
                else
                    shadow_hold = CNT_W'(nxt);
            end
            else
                shadow_hold = '0;
        end
        r.held_key = shadow_latched;
        return r;
    endfunction

    task automatic add_sample(input logic [SAMPLE_W-1:0] smp);
        stim_row_t row;
        row.kind = ROW_SAMPLE;
        row.idx = '0;
        row.val = '0;
        row.smp = smp;
        row.typed = 1'b0;
        row.res = '0;
        directed.push_back(row);
    endtask

    task automatic add_typed(input logic [SAMPLE_W-1:0] smp, input logic ev,
                             input logic [KEY_W-1:0] num, input logic [KEY_W-1:0] held);
        stim_row_t row;
        row.kind = ROW_SAMPLE;
        row.idx = '0;
        row.val = '0;
        row.smp = smp;
        row.typed = 1'b1;
        row.res.key_event = ev;
        row.res.key_number = num;
        row.res.held_key = held;
        directed.push_back(row);
    endtask

    task automatic add_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        stim_row_t row;
        row.kind = ROW_WRITE;
        row.idx = idx;
        row.val = val;
        row.smp = '0;
        row.typed = 1'b0;
        row.res = '0;
        directed.push_back(row);
    endtask

    // Offer one sample request; predict its report once it is taken.
    task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input bit typed,
                               input result_t typed_res);
        result_t pred;
        bit taken;
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(IN_TDATA_W - SAMPLE_W){1'b0}}, smp};
        do
        begin
            @(posedge clk);
            taken = s_tready;
        end while (!taken);
        pred = debounce_step(smp);
        expected_reports.push_back(typed ? typed_res : pred);
        samples_sent++;
    endtask

    task automatic wait_drained();
        while (expected_reports.size() != 0)
            @(posedge clk);
    endtask

    // Registers change only with the pipe empty.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (2) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TOLERANCE:     shadow_tol = val[TOL_W-1:0];
            REG_REPEAT_THR:    shadow_thr = val;
            REG_REPEAT_RELOAD: shadow_reload = val;
            default: ;
        endcase
        writes_done++;
    endtask

    // Receiver: random stalls plus an occasional long hold-off.
    always @(posedge clk)
    begin
        if (hold_served != hold_reqs)
        begin
            hold_served <= hold_reqs;
            hold_left <= HOLDOFF_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall);
    end

    // Report checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            reports_seen++;
            got.key_event = m_tdata[0];
            got.key_number = m_tdata[5:1];
            got.held_key = m_tdata[10:6];
            if (got.key_event)
                events_seen++;
            if (expected_reports.size() == 0)
            begin
                $error("report with no sample pending: m_tdata=%h", m_tdata);
                error_cnt++;
            end
            else
            begin
                want = expected_reports.pop_front();
                if (got.key_event !== want.key_event)
                begin
                    $error("key_event: expected %0d, actual %0d", want.key_event, got.key_event);
                    error_cnt++;
                end
                if (got.key_number !== want.key_number)
                begin
                    $error("key_number: expected %0d, actual %0d",
                           want.key_number, got.key_number);
                    error_cnt++;
                end
                if (got.held_key !== want.held_key)
                begin
                    $error("held_key: expected %0d, actual %0d", want.held_key, got.held_key);
                    error_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no request moved for %0d cycles", idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int n;
        int pick;
        int key;
        int len;
        int v;
        int tol;
        int thr;
        bit paused;
        result_t none;
        none = '0;
        paused = 1'b0;

        // reset settings: tolerance 16, threshold 100, reload 90
        add_typed(10'd0, 1'b0, 5'd0, 5'd0);
        add_typed(10'd1023, 1'b0, 5'd0, 5'd0);
        add_typed(10'd1023, 1'b0, 5'd0, 5'd0);
        add_typed(10'd1023, 1'b1, 5'd16, 5'd16);
        // another key held steady while 16 is latched
        add_sample(10'd64);
        add_sample(10'd64);
        add_sample(10'd64);
        add_typed(10'd47, 1'b0, 5'd0, 5'd0);
        add_sample(10'd48);
        add_sample(10'd48);
        add_sample(10'd48);
        // zero tolerance, threshold 1: every steady sample repeats
        add_write(REG_TOLERANCE, 8'd0);
        add_write(REG_REPEAT_THR, 8'd1);
        add_write(REG_REPEAT_RELOAD, 8'd0);
        add_typed(10'd63, 1'b0, 5'd0, 5'd0);
        add_sample(10'd512);
        add_sample(10'd512);
        add_sample(10'd512);
        add_sample(10'd512);
        add_sample(10'd65);
        // widest windows, threshold zero, reload above threshold
        add_write(REG_TOLERANCE, 8'd31);
        add_write(REG_REPEAT_THR, 8'd0);
        add_write(REG_REPEAT_RELOAD, 8'd254);
        add_typed(10'd32, 1'b0, 5'd0, 5'd0);
        add_sample(10'd993);
        add_sample(10'd993);
        add_sample(10'd993);
        add_sample(10'd33);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_WRITE)
                write_reg(directed[i].idx, directed[i].val);
            else
                push_sample(directed[i].smp, directed[i].typed, directed[i].res);
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_TOLERANCE, 8'd31);
                    write_reg(REG_REPEAT_THR, 8'd255);
                    write_reg(REG_REPEAT_RELOAD, 8'd254);
                    send_idle = 0;
                    recv_stall <= 0;
                end
                1:
                begin
                    write_reg(REG_TOLERANCE, 8'd0);
                    write_reg(REG_REPEAT_THR, 8'd1);
                    write_reg(REG_REPEAT_RELOAD, 8'd0);
                    send_idle = 67;
                    recv_stall <= 0;
                end
                2:
                begin
                    write_reg(REG_TOLERANCE, 8'($urandom_range(0, 31)));
                    write_reg(REG_REPEAT_THR, 8'($urandom_range(1, 16)));
                    write_reg(REG_REPEAT_RELOAD, 8'($urandom_range(0, 20)));
                    send_idle = 0;
                    recv_stall <= 67;
                end
                default:
                begin
                    thr = $urandom_range(20, 60);
                    write_reg(REG_TOLERANCE, 8'($urandom_range(0, 31)));
                    write_reg(REG_REPEAT_THR, 8'(thr));
                    write_reg(REG_REPEAT_RELOAD, 8'($urandom_range(0, thr - 1)));
                    send_idle = 16;
                    recv_stall <= 16;
                end
            endcase
            tol = shadow_tol;
            n = 0;
            while (n < RANDOM_PER_PHASE)
            begin
                if (ph == 0 && n >= 100 && hold_reqs == 0)
                    hold_reqs <= hold_reqs + 1;
                if (ph == 2 && n >= 130 && !paused)
                begin
                    s_tvalid <= 1'b0;
                    wait_drained();
                    paused = 1'b1;
                end
                pick = $urandom_range(99);
                if (pick < 70)
                begin
                    // a key pressed and held, with jitter inside its window
                    key = $urandom_range(1, KEY_COUNT_DEF);
                    len = ($urandom_range(9) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 12);
                    for (int j = 0; j < len && n < RANDOM_PER_PHASE; j++)
                    begin
                        v = key * KEY_SPACING_DEF + $urandom_range(0, 2 * tol) - tol;
                        if (v > 1023)
                            v = 1023;
                        push_sample(10'(v), 1'b0, none);
                        n++;
                    end
                end
                else if (pick < 85)
                begin
                    v = $urandom_range(0, KEY_SPACING_DEF - 1 - tol);
                    push_sample(10'(v), 1'b0, none);
                    n++;
                end
                else
                begin
                    push_sample(10'($urandom_range(0, 1023)), 1'b0, none);
                    n++;
                end
            end
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (5) @(posedge clk);
        $display("Sent %0d samples in four stall mixes; %0d reports, %0d key events, %0d writes.",
                 samples_sent, reports_seen, events_seen, writes_done);
        if (error_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/alkd_pkg.sv
sv/alkd_front.sv
sv/alkd_fifo.sv
sv/alkd_back.sv
sv/adc_ladder_key_debounce.sv
sv/alkd_checker.sv
test/tb_top.sv
